### hw/rtl/dmsw_pkg.sv
`timescale 1ns / 1ps

package dmsw_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_IRQ     = 2'd2;

    // Action codes carried in m_tuser.
    localparam logic [2:0] ACT_MOTOR_ON  = 3'd0;
    localparam logic [2:0] ACT_SEEK      = 3'd1;
    localparam logic [2:0] ACT_WRITE     = 3'd2;
    localparam logic [2:0] ACT_MOTOR_OFF = 3'd3;
    localparam logic [2:0] ACT_DONE      = 3'd4;
    localparam logic [2:0] ACT_BUSY      = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_SECTORS_PER_TRACK = 2'd0;
    localparam logic [1:0] REG_SPINUP_TICKS      = 2'd1;
    localparam logic [1:0] REG_COOLDOWN_TICKS    = 2'd2;

    // Field widths fixed by the interface.
    localparam int LBA_FIELD_W = 24;
    localparam int TRACK_W     = 24;
    localparam int SECTOR_W    = 8;
    localparam int TICK_W      = 8;
    localparam int CFG_W       = 8;

    // Status returned by the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hw/rtl/dmsw_div.sv
`timescale 1ns / 1ps

module dmsw_div #(
    parameter int LBA_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [LBA_BITS-1:0]           dividend,
    input  logic [dmsw_pkg::SECTOR_W-1:0] divisor,
    output logic [LBA_BITS-1:0]           quotient,
    output logic [dmsw_pkg::SECTOR_W-1:0] remainder,
    output dmsw_pkg::div_status_t         status
);

    localparam int CNT_W = $clog2(LBA_BITS + 1);
    localparam int SW    = dmsw_pkg::SECTOR_W;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [LBA_BITS-1:0] quo_reg, quo_next;
    logic [SW-1:0]       rem_reg, rem_next;
    logic [SW-1:0]       dsr_reg, dsr_next;
    logic [SW:0]         trial;
    logic                fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign trial = {rem_reg, quo_reg[LBA_BITS-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            cnt_next = CNT_W'(LBA_BITS);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[LBA_BITS-2:0], fits};
            rem_next = fits ? SW'(trial - {1'b0, dsr_reg}) : trial[SW-1:0];
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = cnt_reg != '0;
    assign status.done = done_reg;

endmodule

### hw/rtl/disk_motor_seek_write_sequencer.sv
`timescale 1ns / 1ps
// An accepted item that causes no seek buffers its result for the output register, a seek
// first waits for the divider; a second result, if any, is loaded after the first.
// One item is handled at a time; an item with no result leaves the input ready, others
// hold it off until their last result is loaded, which any m_tready stall delays.
// Reset: synchronous active-low aresetn returns the sequencer to idle with cleared
// counters and flags and loads the registers with 63, 1 and 4.
module disk_motor_seek_write_sequencer #(
    parameter int LBA_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // lba_sector[23:0], motor_running[24], arm_on_track[25]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // track[23:0], sector_in_track[31:24]
    output logic [2:0]  m_tuser,  // action[2:0]
    output logic        m_tlast
);

    localparam int TW = dmsw_pkg::TICK_W;
    localparam int SW = dmsw_pkg::SECTOR_W;
    localparam int RW = dmsw_pkg::TRACK_W;

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_SPINUP   = 2'd1;
    localparam logic [1:0] PH_WAIT     = 2'd2;
    localparam logic [1:0] PH_COOLDOWN = 2'd3;

    // Item handling states.
    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_DIV  = 2'd1;
    localparam logic [1:0] C_EMIT = 2'd2;

    logic [1:0]          ctl_reg, ctl_next;
    logic [1:0]          phase_reg, phase_next;
    logic [TW-1:0]       tick_reg, tick_next;
    logic                arm_seen_reg, arm_seen_next;
    logic                data_seen_reg, data_seen_next;
    logic [LBA_BITS-1:0] lba_reg, lba_next;
    logic [SW-1:0]       spt_reg, spt_next;
    logic [TW-1:0]       spinup_reg, spinup_next;
    logic [TW-1:0]       cool_reg, cool_next;
    logic [2:0]          res0_reg, res0_next;
    logic [2:0]          res1_reg, res1_next;
    logic                res_two_reg, res_two_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [2:0]          m_tuser_reg, m_tuser_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                accept;
    logic [1:0]          op;
    logic [LBA_BITS-1:0] lba_in;
    logic                motor_in;
    logic                arm_in;
    logic [TW-1:0]       tick_inc;
    logic                out_free;
    logic                div_start;
    logic [LBA_BITS-1:0] div_dividend;
    logic [SW-1:0]       divisor;
    logic [LBA_BITS-1:0] div_quo;
    logic [SW-1:0]       div_rem;
    dmsw_pkg::div_status_t div_st;

    assign op       = s_tuser;
    assign lba_in   = LBA_BITS'(s_tdata[dmsw_pkg::LBA_FIELD_W-1:0]);
    assign motor_in = s_tdata[24];
    assign arm_in   = s_tdata[25];

    assign s_tready = ctl_reg == C_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign tick_inc = (tick_reg != {TW{1'b1}}) ? tick_reg + 1'b1 : tick_reg;
    assign divisor  = (spt_reg == '0) ? SW'(1) : spt_reg;

    // The serial divider splits the LBA into track and sector.
    dmsw_div #(
        .LBA_BITS (LBA_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_st)
    );

    // Sequencer state update on an accepted item or a finished division, then result emission.
    always_comb begin
        ctl_next       = ctl_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        arm_seen_next  = arm_seen_reg;
        data_seen_next = data_seen_reg;
        lba_next       = lba_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        res_two_next   = res_two_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tuser_next   = m_tuser_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        div_start      = 1'b0;
        div_dividend   = lba_reg;

        case (ctl_reg)
            C_IDLE: begin
                if (accept) begin
                    case (op)
                        dmsw_pkg::OP_REQUEST: begin
                            if (phase_reg != PH_IDLE) begin
                                res0_next    = dmsw_pkg::ACT_BUSY;
                                res_two_next = 1'b0;
                                ctl_next     = C_EMIT;
                            end else begin
                                lba_next = lba_in;
                                if (!motor_in) begin
                                    tick_next    = '0;
                                    phase_next   = PH_SPINUP;
                                    res0_next    = dmsw_pkg::ACT_MOTOR_ON;
                                    res_two_next = 1'b0;
                                    ctl_next     = C_EMIT;
                                end else begin
                                    div_start      = 1'b1;
                                    div_dividend   = lba_in;
                                    arm_seen_next  = 1'b0;
                                    data_seen_next = 1'b0;
                                    tick_next      = '0;
                                    phase_next     = PH_WAIT;
                                    ctl_next       = C_DIV;
                                end
                            end
                        end
                        dmsw_pkg::OP_TICK: begin
                            if (phase_reg == PH_SPINUP) begin
                                tick_next = tick_inc;
                                if (tick_inc >= spinup_reg) begin
                                    div_start      = 1'b1;
                                    arm_seen_next  = 1'b0;
                                    data_seen_next = 1'b0;
                                    tick_next      = '0;
                                    phase_next     = PH_WAIT;
                                    ctl_next       = C_DIV;
                                end
                            end else if (phase_reg == PH_COOLDOWN) begin
                                tick_next = tick_inc;
                                if (tick_inc >= cool_reg) begin
                                    tick_next    = '0;
                                    phase_next   = PH_IDLE;
                                    res0_next    = dmsw_pkg::ACT_DONE;
                                    res_two_next = 1'b0;
                                    ctl_next     = C_EMIT;
                                end
                            end
                        end
                        dmsw_pkg::OP_IRQ: begin
                            if (phase_reg == PH_WAIT) begin
                                if ((arm_in || arm_seen_reg) && (!arm_in || data_seen_reg)) begin
                                    arm_seen_next  = 1'b0;
                                    data_seen_next = 1'b0;
                                    tick_next      = '0;
                                    phase_next     = PH_COOLDOWN;
                                    res0_next      = dmsw_pkg::ACT_WRITE;
                                    res1_next      = dmsw_pkg::ACT_MOTOR_OFF;
                                    res_two_next   = 1'b1;
                                    ctl_next       = C_EMIT;
                                end else if (arm_in) begin
                                    arm_seen_next = 1'b1;
                                end else begin
                                    data_seen_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            C_DIV: begin
                if (div_st.done) begin
                    res0_next    = dmsw_pkg::ACT_SEEK;
                    res_two_next = 1'b0;
                    ctl_next     = C_EMIT;
                end
            end
            C_EMIT: begin
            end
            default: begin
                ctl_next = C_IDLE;
            end
        endcase

        // Output register: load the next buffered result once the slot frees up.
        if (ctl_reg == C_EMIT && out_free) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = res0_reg;
            m_tlast_next  = !res_two_reg;
            if (res0_reg == dmsw_pkg::ACT_SEEK) begin
                m_tdata_next = {div_rem, RW'(div_quo)};
            end else begin
                m_tdata_next = '0;
            end
            if (res_two_reg) begin
                res0_next    = res1_reg;
                res_two_next = 1'b0;
            end else begin
                ctl_next = C_IDLE;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Configuration writes.
    always_comb begin
        spt_next    = spt_reg;
        spinup_next = spinup_reg;
        cool_next   = cool_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                dmsw_pkg::REG_SECTORS_PER_TRACK: spt_next    = cfg_wdata;
                dmsw_pkg::REG_SPINUP_TICKS:      spinup_next = cfg_wdata;
                dmsw_pkg::REG_COOLDOWN_TICKS:    cool_next   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Control and configuration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg       <= C_IDLE;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            arm_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            lba_reg       <= '0;
            spt_reg       <= SW'(63);
            spinup_reg    <= TW'(1);
            cool_reg      <= TW'(4);
            res_two_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            ctl_reg       <= ctl_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            arm_seen_reg  <= arm_seen_next;
            data_seen_reg <= data_seen_next;
            lba_reg       <= lba_next;
            spt_reg       <= spt_next;
            spinup_reg    <= spinup_next;
            cool_reg      <= cool_next;
            res_two_reg   <= res_two_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        res0_reg    <= res0_next;
        res1_reg    <= res1_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The divider reports completion only while a seek is being worked out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> ctl_reg == C_DIV)
        else $error("Divider finished outside a seek computation.");

    // Both event flags set at once means the write was never issued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(arm_seen_reg && data_seen_reg))
        else $error("Arm and data events both pending.");

    // The tick counter runs only during spin-up or cool-down.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_reg != '0 |-> (phase_reg == PH_SPINUP || phase_reg == PH_COOLDOWN))
        else $error("Tick counter left nonzero outside a timed phase.");

    // No new item is taken while the divider is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.busy |-> !s_tready)
        else $error("Input ready during a division.");

endmodule

### sim/disk_write_seq_checker.sv
`timescale 1ns / 1ps

module disk_write_seq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // lba_sector[23:0], motor_running[24], arm_on_track[25]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,  // track[23:0], sector_in_track[31:24]
    input  logic [2:0]  m_tuser,  // action[2:0]
    input  logic        m_tlast,
    output int          n_waiting,
    output int          n_failures
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SPINUP,
        SEQ_WAIT,
        SEQ_COOLDOWN
    } seq_phase_t;

    typedef struct packed {
        logic [2:0]                    action;
        logic [dmsw_pkg::TRACK_W-1:0]  track;
        logic [dmsw_pkg::SECTOR_W-1:0] sector;
        logic                          last;
    } drive_cmd_t;

    // Commands the sequencer still owes, oldest first.
    drive_cmd_t expected_cmds[$];

    // Shadow of the register file.
    logic [dmsw_pkg::CFG_W-1:0] spt_reg;
    logic [dmsw_pkg::CFG_W-1:0] spinup_reg;
    logic [dmsw_pkg::CFG_W-1:0] cooldown_reg;

    // Shadow of the sequencer state.
    seq_phase_t                       phase;
    logic [dmsw_pkg::TICK_W-1:0]      tick_count;
    logic                             arm_seen;
    logic                             data_seen;
    logic [dmsw_pkg::LBA_FIELD_W-1:0] pending_lba;

    task automatic queue_cmd(input logic [2:0] act, input logic [23:0] trk,
                             input logic [7:0] sec, input logic lst);
        drive_cmd_t cmd;
        cmd.action = act;
        cmd.track  = trk;
        cmd.sector = sec;
        cmd.last   = lst;
        expected_cmds.push_back(cmd);
        n_waiting++;
    endtask

    // Split the latched LBA into track and sector; a zero divisor acts as one.
    task automatic issue_seek();
        logic [23:0] divisor;
        logic [23:0] remainder;
        divisor   = (spt_reg == 8'd0) ? 24'd1 : {16'd0, spt_reg};
        remainder = pending_lba % divisor;
        queue_cmd(dmsw_pkg::ACT_SEEK, pending_lba / divisor, remainder[7:0], 1'b1);
        arm_seen   = 1'b0;
        data_seen  = 1'b0;
        tick_count = '0;
        phase      = SEQ_WAIT;
    endtask

    task automatic sequence_item(input logic [1:0] op, input logic [23:0] lba,
                                 input logic motor, input logic arm);
        case (op)
            dmsw_pkg::OP_REQUEST: begin
                if (phase != SEQ_IDLE) begin
                    queue_cmd(dmsw_pkg::ACT_BUSY, 24'd0, 8'd0, 1'b1);
                end else begin
                    pending_lba = lba;
                    if (!motor) begin
                        tick_count = '0;
                        phase      = SEQ_SPINUP;
                        queue_cmd(dmsw_pkg::ACT_MOTOR_ON, 24'd0, 8'd0, 1'b1);
                    end else begin
                        issue_seek();
                    end
                end
            end
            dmsw_pkg::OP_TICK: begin
                // Ticks only count during spin-up and cool-down; the count saturates.
                if (phase == SEQ_SPINUP || phase == SEQ_COOLDOWN) begin
                    if (tick_count != 8'hFF) tick_count = tick_count + 8'd1;
                    if (phase == SEQ_SPINUP) begin
                        if (tick_count >= spinup_reg) issue_seek();
                    end else if (tick_count >= cooldown_reg) begin
                        tick_count = '0;
                        phase      = SEQ_IDLE;
                        queue_cmd(dmsw_pkg::ACT_DONE, 24'd0, 8'd0, 1'b1);
                    end
                end
            end
            dmsw_pkg::OP_IRQ: begin
                // Both controller events must arrive, in either order.
                if (phase == SEQ_WAIT) begin
                    if (arm) arm_seen = 1'b1;
                    else data_seen = 1'b1;
                    if (arm_seen && data_seen) begin
                        arm_seen   = 1'b0;
                        data_seen  = 1'b0;
                        tick_count = '0;
                        phase      = SEQ_COOLDOWN;
                        queue_cmd(dmsw_pkg::ACT_WRITE, 24'd0, 8'd0, 1'b0);
                        queue_cmd(dmsw_pkg::ACT_MOTOR_OFF, 24'd0, 8'd0, 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic int field_diff(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_cmd(input drive_cmd_t got);
        drive_cmd_t want;
        if (expected_cmds.size() == 0) begin
            $display({"%0t: unexpected result: expected none, ",
                      "actual action %0d track %0d sector %0d last %0d"},
                     $time, got.action, got.track, got.sector, got.last);
            n_failures++;
        end else begin
            want = expected_cmds.pop_front();
            n_waiting--;
            n_failures += field_diff("action", want.action, got.action)
                        + field_diff("track", want.track, got.track)
                        + field_diff("sector", want.sector, got.sector)
                        + field_diff("last", want.last, got.last);
        end
    endtask

    // Results are checked before the new item is predicted, so a result never
    // matches an expectation queued at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg      = 8'd63;
            spinup_reg   = 8'd1;
            cooldown_reg = 8'd4;
            phase        = SEQ_IDLE;
            tick_count   = '0;
            arm_seen     = 1'b0;
            data_seen    = 1'b0;
            pending_lba  = '0;
            expected_cmds.delete();
            n_waiting    = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_cmd({m_tuser, m_tdata[23:0], m_tdata[31:24], m_tlast});
            if (cfg_wr_en) begin
                case (cfg_addr)
                    dmsw_pkg::REG_SECTORS_PER_TRACK: spt_reg = cfg_wdata;
                    dmsw_pkg::REG_SPINUP_TICKS:      spinup_reg = cfg_wdata;
                    dmsw_pkg::REG_COOLDOWN_TICKS:    cooldown_reg = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                sequence_item(s_tuser, s_tdata[23:0], s_tdata[24], s_tdata[25]);
        end
    end

endmodule

### sim/tb_disk_motor_seek_write_sequencer.sv
`timescale 1ns / 1ps

module tb_disk_motor_seek_write_sequencer;

    localparam int ITEM_TARGET    = 1950;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // Operation code the sequencer does not define.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;  // lba_sector[23:0], motor_running[24], arm_on_track[25]
    logic [1:0]  s_tuser;  // operation[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;  // track[23:0], sector_in_track[31:24]
    logic [2:0]  m_tuser;  // action[2:0]
    logic        m_tlast;

    int   n_waiting;
    int   n_failures;
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    int   quiet_cycles = 0;
    bit   gaps_on = 1'b1;
    int   items_sent = 0;

    // Register values currently programmed, used to size tick runs.
    logic [7:0] spt_now;
    logic [7:0] spin_now;
    logic [7:0] cool_now;

    always #5 aclk = ~aclk;

    disk_motor_seek_write_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    disk_write_seq_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .n_waiting  (n_waiting),
        .n_failures (n_failures)
    );

    // Record each edge's handshakes and count cycles in which nothing moves.
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Result side: a random stall before each item, none in burst phases.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = gaps_on ? int'($urandom_range(0, 7)) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_taken);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [1:0] op, input logic [23:0] lba,
                             input logic motor, input logic arm, input bit counted);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, arm, motor, lba};
        do @(negedge aclk); while (!s_taken);
        if (counted) items_sent++;
    endtask

    // Hold off until every owed result has arrived and the divider is surely done.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (n_waiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] spt, input logic [7:0] spin,
                                input logic [7:0] cool);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= dmsw_pkg::REG_SECTORS_PER_TRACK;
        cfg_wdata <= spt;
        @(negedge aclk);
        cfg_addr  <= dmsw_pkg::REG_SPINUP_TICKS;
        cfg_wdata <= spin;
        @(negedge aclk);
        cfg_addr  <= dmsw_pkg::REG_COOLDOWN_TICKS;
        cfg_wdata <= cool;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        spt_now  = spt;
        spin_now = spin;
        cool_now = cool;
    endtask

    // Sector numbers lean toward the ends of the range and small values.
    function automatic logic [23:0] pick_lba();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return {14'd0, r[9:0]};
            default: return r[23:0];
        endcase
    endfunction

    task automatic send_noise(input bit allow_request);
        logic [31:0] r;
        logic [1:0]  op;
        r  = $urandom;
        op = r[1:0];
        if (!allow_request && op == dmsw_pkg::OP_REQUEST) op = dmsw_pkg::OP_TICK;
        send_item(op, pick_lba(), r[2], r[3], allow_request && op != OP_UNUSED);
    endtask

    // One sector write from request to done, with stray items mixed in.
    task automatic run_write_job(input bit cold_start);
        bit motor_on;
        bit arm_done;
        bit data_done;
        bit kind;
        int ticks;
        motor_on = cold_start ? 1'b0 : 1'($urandom_range(0, 1));
        send_item(dmsw_pkg::OP_REQUEST, pick_lba(), motor_on, 1'($urandom_range(0, 1)),
                  1'b1);
        if (!motor_on) begin
            ticks = (spin_now == 8'd0 ? 1 : int'(spin_now)) + int'($urandom_range(0, 2));
            for (int k = 0; k < ticks; k++) begin
                if ($urandom_range(0, 7) == 0) send_noise(1'b1);
                // Now and then lower the spin-up count while the wait is under way.
                if (k == 1 && spin_now > 8'd2 && $urandom_range(0, 3) == 0) begin
                    drain_pipeline();
                    program_regs(spt_now, 8'($urandom_range(0, spin_now - 1)), cool_now);
                end
                send_item(dmsw_pkg::OP_TICK, pick_lba(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b1);
            end
        end
        // A few jobs are abandoned before the controller events.
        if ($urandom_range(0, 15) == 0) return;
        arm_done  = 1'b0;
        data_done = 1'b0;
        while (!(arm_done && data_done)) begin
            if ($urandom_range(0, 5) == 0) send_noise(1'b1);
            kind = 1'($urandom_range(0, 1));
            send_item(dmsw_pkg::OP_IRQ, pick_lba(), 1'($urandom_range(0, 1)), kind, 1'b1);
            if (kind) arm_done = 1'b1;
            else data_done = 1'b1;
        end
        ticks = (cool_now == 8'd0 ? 1 : int'(cool_now)) + int'($urandom_range(0, 2));
        repeat (ticks) begin
            if ($urandom_range(0, 7) == 0) send_noise(1'b1);
            send_item(dmsw_pkg::OP_TICK, pick_lba(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    initial begin
        int jobs;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = dmsw_pkg::REG_SECTORS_PER_TRACK;
        cfg_wdata = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tuser   = dmsw_pkg::OP_TICK;
        spt_now   = 8'd63;
        spin_now  = 8'd1;
        cool_now  = 8'd4;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Stray items while idle are dropped.
        send_item(dmsw_pkg::OP_TICK, 24'hFFFFFF, 1'b1, 1'b1, 1'b0);
        send_item(dmsw_pkg::OP_IRQ, 24'hFFFFFF, 1'b1, 1'b1, 1'b0);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b0, 1'b0);
        send_item(OP_UNUSED, 24'hFFFFFF, 1'b1, 1'b1, 1'b0);

        // Cold start at the top sector: busy request and early event during spin-up.
        send_item(dmsw_pkg::OP_REQUEST, 24'hFFFFFF, 1'b0, 1'b1, 1'b1);
        send_item(dmsw_pkg::OP_REQUEST, 24'h123456, 1'b1, 1'b0, 1'b1);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b1, 1'b1);
        send_item(dmsw_pkg::OP_TICK, 24'd0, 1'b0, 1'b0, 1'b1);
        // Tick in the wait phase, then a repeated arm event before data ready.
        send_item(dmsw_pkg::OP_TICK, 24'd0, 1'b0, 1'b0, 1'b1);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b1, 1'b1);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b1, 1'b1);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b0, 1'b1);
        // Event and request during cool-down, then the cool-down ticks.
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b0, 1'b1);
        send_item(dmsw_pkg::OP_REQUEST, 24'd7, 1'b0, 1'b0, 1'b1);
        repeat (4) send_item(dmsw_pkg::OP_TICK, 24'd0, 1'b0, 1'b0, 1'b1);

        // Warm start at sector zero, data ready ahead of arm ready.
        send_item(dmsw_pkg::OP_REQUEST, 24'd0, 1'b1, 1'b0, 1'b1);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b0, 1'b1);
        send_item(dmsw_pkg::OP_IRQ, 24'd0, 1'b0, 1'b1, 1'b1);
        repeat (4) send_item(dmsw_pkg::OP_TICK, 24'd0, 1'b0, 1'b0, 1'b1);

        // Register settings: zeros, maxima, ones, then random small tick counts.
        for (int phase_no = 0; items_sent < ITEM_TARGET; phase_no++) begin
            drain_pipeline();
            case (phase_no)
                0: program_regs(8'd0, 8'd0, 8'd0);
                1: program_regs(8'd255, 8'd255, 8'd255);
                2: program_regs(8'd1, 8'd1, 8'd1);
                default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
                                      8'($urandom_range(0, 6)));
            endcase
            gaps_on = (phase_no % 4 != 3);
            jobs = (phase_no == 1) ? 1 : int'($urandom_range(4, 10));
            repeat (jobs) begin
                run_write_job(phase_no == 1);
                repeat ($urandom_range(0, 3)) send_noise(1'b0);
            end
        end

        drain_pipeline();
        if (n_failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
